// ----- src/sha1_pkg.sv -----
// Package for the SHA-1 engine: sequencer states, initial hash values,
// round constants and the round function.
// Depends on nothing; used by sha1_digest.
package sha1_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  typedef logic [31:0] word_t;

  localparam int unsigned NumHash   = 5;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned BlockBits = 512;

  localparam word_t Iv [NumHash] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t round_f(input logic [6:0] r, input word_t b,
                                    input word_t c, input word_t d);
    word_t res;
    if (r < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      res = b ^ c ^ d;
    end else if (r < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic word_t round_k(input logic [6:0] r);
    word_t res;
    if (r < 7'd20) begin
      res = K0;
    end else if (r < 7'd40) begin
      res = K1;
    end else if (r < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

// ----- src/sha1_digest.sv -----
// SHA-1 engine top level: byte packer, padding sequencer, one-round-per-cycle
// compression with a rolling schedule, and digest word output.
// Depends on sha1_pkg.
//
//  channel | dir | tdata            | tuser        | tlast
//  s_*     | in  | [7:0] msg_byte   | byte_present | end_of_message
//  m_*     | out | [31:0] digest_wd | -            | last_word
//
// One data byte per cycle in idle; a full block then adds 80 rounds and 1 add state.
// End of message: one pad byte per cycle up to the block end (up to 72 pad bytes with
// an extra block), the rounds and add of each block, then 5 output transactions.
// s_tready is high only in idle; nothing is accepted while padding, hashing
// or emitting. Output words hold while m_tready is low.
// Reset is synchronous; no clearing pass is needed.
module sha1_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast    // last_word
);
  import sha1_pkg::*;

  state_t state, state_next;

  word_t chain [NumHash];
  word_t wa, wb, wc, wd, we;
  logic [BlockBits-1:0] blk;
  logic [63:0] bit_count;
  logic [5:0]  slot;
  logic [6:0]  round;
  logic [2:0]  out_idx;
  logic        pad_active, done80, len_phase, final_blk;

  logic        s_fire, m_fire;
  logic        ins_en, use_len, wrap;
  logic [7:0]  ins_byte;
  word_t       w0, w2, w8, w13, w_new, t_sum;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  assign w0  = blk[511:480];
  assign w2  = blk[447:416];
  assign w8  = blk[255:224];
  assign w13 = blk[95:64];
  assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                  w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};
  assign t_sum = {wa[26:0], wa[31:27]} + round_f(round, wb, wc, wd) + we
                 + round_k(round) + w0;

  assign use_len = done80 && (len_phase || (slot == 6'd56));
  assign wrap    = (slot == 6'd63);

  always_comb begin
    ins_en   = 1'b0;
    ins_byte = s_tdata;
    unique case (state)
      S_IDLE: ins_en = s_fire && s_tuser;
      S_PAD: begin
        ins_en = 1'b1;
        if (!done80) begin
          ins_byte = PadByte;
        end else if (use_len) begin
          ins_byte = bit_count[63:56];
        end else begin
          ins_byte = 8'h00;
        end
      end
      default: ins_en = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          if (s_tuser && wrap) begin
            state_next = S_ROUND;
          end else if (s_tlast) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD:   if (wrap) state_next = S_ROUND;
      S_ROUND: if (round == 7'(NumRounds - 1)) state_next = S_ADD;
      S_ADD: begin
        if (final_blk) begin
          state_next = S_OUT;
        end else if (pad_active) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT:   if (m_fire && out_idx == 3'(NumHash - 1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    m_tvalid = (state == S_OUT);
    m_tdata  = chain[out_idx];
    m_tlast  = (out_idx == 3'(NumHash - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chain      <= Iv;
      bit_count  <= '0;
      slot       <= '0;
      round      <= '0;
      out_idx    <= '0;
      pad_active <= 1'b0;
      done80     <= 1'b0;
      len_phase  <= 1'b0;
      final_blk  <= 1'b0;
    end else begin
      state <= state_next;
      if (ins_en) begin
        blk  <= {blk[BlockBits-9:0], ins_byte};
        slot <= slot + 6'd1;
        if (wrap) begin
          {wa, wb, wc, wd, we} <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
          round <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            if (s_tuser) bit_count <= bit_count + 64'd8;
            if (s_tlast) pad_active <= 1'b1;
          end
        end
        S_PAD: begin
          done80 <= 1'b1;
          if (use_len) begin
            len_phase <= 1'b1;
            bit_count <= {bit_count[55:0], 8'h00};
            if (wrap) final_blk <= 1'b1;
          end
        end
        S_ROUND: begin
          blk   <= {blk[BlockBits-33:0], w_new};
          wa    <= t_sum;
          wb    <= wa;
          wc    <= {wb[1:0], wb[31:2]};
          wd    <= wc;
          we    <= wd;
          round <= round + 7'd1;
        end
        S_ADD: begin
          chain[0] <= chain[0] + wa;
          chain[1] <= chain[1] + wb;
          chain[2] <= chain[2] + wc;
          chain[3] <= chain[3] + wd;
          chain[4] <= chain[4] + we;
        end
        S_OUT: begin
          if (m_fire) begin
            if (out_idx == 3'(NumHash - 1)) begin
              out_idx    <= '0;
              chain      <= Iv;
              bit_count  <= '0;
              slot       <= '0;
              pad_active <= 1'b0;
              done80     <= 1'b0;
              len_phase  <= 1'b0;
              final_blk  <= 1'b0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while digest is presented");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_tlast) |=> (!m_tvalid && s_tready && slot == 6'd0))
    else $error("engine not cleared after last digest word");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (round < 7'(NumRounds)))
    else $error("round counter out of range");

  a_final_pad: assert property (@(posedge clk) disable iff (rst)
    final_blk |-> (pad_active && done80 && len_phase))
    else $error("final block flagged outside of length padding");
`endif

endmodule
